// ===== rtl/trab_pkg.sv =====
// Shared types and constants of the telemetry ring acknowledge buffer.
// Depends on nothing; every other file of the block but trab_ram imports it.
package trab_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;

	localparam int unsigned SEQ_W     = 64;
	localparam int unsigned STAMP_W   = 48;
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned CONF_W    = 32;
	localparam int unsigned SRV_W     = 5;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned CMD_W     = 2;

	localparam int unsigned APB_DW = 64;
	localparam int unsigned APB_AW = 4;

	// Register select: registers sit on 8-byte strides, paddr[3] picks one.
	localparam logic REG_SERVER_MASK    = 1'b0;
	localparam logic REG_START_SEQUENCE = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 2'd0,
		CMD_CONFIRM = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_CLEAR   = 2'd3
	} command_t;

	typedef struct packed {
		logic [SEQ_W-1:0]     seq;
		logic [STAMP_W-1:0]   stamp;
		logic [PAYLOAD_W-1:0] payload;
		logic [CONF_W-1:0]    conf;
	} record_t;

	localparam int unsigned REC_W = $bits(record_t);

	// Controller to datapath.
	typedef struct packed {
		logic take;    // latch the accepted word
		logic exec;    // apply add or clear to ring state
		logic prep;    // load the scan start slot, clear the scan results
		logic scan;    // issue one record read
		logic finish;  // load the output register
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic issue_done;  // every stored record has been read
		logic out_free;    // output register can take a result this cycle
	} dp_status_t;

endpackage

// ===== rtl/trab_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on trab_pkg for field widths and the command type.
interface trab_req_if;
	import trab_pkg::*;

	logic                 valid;
	logic                 ready;
	command_t             command;
	logic [PAYLOAD_W-1:0] payload;
	logic [STAMP_W-1:0]   stamp_ms;
	logic [SEQ_W-1:0]     confirm_sequence;
	logic [SRV_W-1:0]     server_index;

	modport source (
		output valid, command, payload, stamp_ms, confirm_sequence, server_index,
		input  ready
	);
	modport sink (
		input  valid, command, payload, stamp_ms, confirm_sequence, server_index,
		output ready
	);
endinterface

interface trab_rsp_if;
	import trab_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [SEQ_W-1:0]     entry_sequence;
	logic [STAMP_W-1:0]   entry_stamp;
	logic [PAYLOAD_W-1:0] entry_payload;
	logic [CONF_W-1:0]    entry_confirmations;
	logic [COUNT_W-1:0]   pending_total;
	logic [COUNT_W-1:0]   stored_total;

	modport source (
		output valid, found, entry_sequence, entry_stamp, entry_payload,
		       entry_confirmations, pending_total, stored_total,
		input  ready
	);
	modport sink (
		input  valid, found, entry_sequence, entry_stamp, entry_payload,
		       entry_confirmations, pending_total, stored_total,
		output ready
	);
endinterface

// ===== rtl/trab_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module trab_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/trab_ctrl.sv =====
// Controller state machine: sequences accept, ring update, record scan and
// result hand-off. Depends on trab_pkg for the command and status structs.
module trab_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  trab_pkg::dp_status_t  status,
	output trab_pkg::ctrl_cmd_t   cmd
);
	import trab_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_FLUSH = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.issue_done) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			// last record was evaluated in the final scan cycle; spare state
			ST_FLUSH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/trab_dp.sv =====
// Datapath: ring pointers, record RAM, scan pipeline and output register.
// Depends on trab_pkg and trab_ram; driven by trab_ctrl commands.
module trab_dp #(
	parameter int unsigned DEPTH = trab_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  trab_pkg::ctrl_cmd_t             cmd,
	output trab_pkg::dp_status_t            status,
	input  trab_pkg::command_t              command,
	input  logic [trab_pkg::PAYLOAD_W-1:0]  payload,
	input  logic [trab_pkg::STAMP_W-1:0]    stamp_ms,
	input  logic [trab_pkg::SEQ_W-1:0]      confirm_sequence,
	input  logic [trab_pkg::SRV_W-1:0]      server_index,
	input  logic [trab_pkg::CONF_W-1:0]     server_mask,
	input  logic [trab_pkg::SEQ_W-1:0]      start_sequence,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [trab_pkg::SEQ_W-1:0]      entry_sequence,
	output logic [trab_pkg::STAMP_W-1:0]    entry_stamp,
	output logic [trab_pkg::PAYLOAD_W-1:0]  entry_payload,
	output logic [trab_pkg::CONF_W-1:0]     entry_confirmations,
	output logic [trab_pkg::COUNT_W-1:0]    pending_total,
	output logic [trab_pkg::COUNT_W-1:0]    stored_total
);
	import trab_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL      = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_X   = (CW+1)'(DEPTH);

	// accepted word
	command_t             cmd_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic [SEQ_W-1:0]     want_q;
	logic [SRV_W-1:0]     bit_q;

	// ring state
	logic [AW-1:0]    wp_q;
	logic [CW-1:0]    fill_q;
	logic [SEQ_W-1:0] next_seq_q;

	// scan
	logic [AW-1:0] rd_slot_q;
	logic [CW-1:0] rd_cnt_q;
	logic          valid_s1;
	logic [AW-1:0] slot_s1;
	logic          matched_q;
	logic          found_q;
	logic [CW-1:0] pend_q;
	record_t       hit_q;

	// output register
	logic                 out_valid_q;
	logic                 found_out_q;
	record_t              rec_out_q;
	logic [COUNT_W-1:0]   pend_out_q;
	logic [COUNT_W-1:0]   stored_out_q;

	// RAM
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [REC_W-1:0] ram_wdata;
	logic [REC_W-1:0] ram_rdata;

	record_t          rec;
	logic             hit_match;
	logic [CONF_W-1:0] conf_new;
	logic             sent;
	logic [CW:0]      oldest_w;
	logic             is_add;

	trab_ram #(
		.WIDTH (REC_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_slot_q),
		.rdata (ram_rdata)
	);

	assign is_add = (cmd_q == CMD_ADD);

	// oldest slot = write pointer minus fill level, modulo the depth
	always_comb begin
		oldest_w = (CW+1)'(wp_q) - (CW+1)'(fill_q);
		if ((CW+1)'(wp_q) < (CW+1)'(fill_q)) begin
			oldest_w = oldest_w + DEPTH_X;
		end
	end

	always_comb begin
		rec       = ram_rdata;
		hit_match = valid_s1 && (cmd_q == CMD_CONFIRM) && !matched_q && (rec.seq == want_q);
		conf_new  = rec.conf;
		if (hit_match) begin
			conf_new = rec.conf | (CONF_W'(1) << bit_q);
		end
		sent = (server_mask == '0) || ((conf_new & server_mask) == server_mask);
	end

	// write port: add in the execute cycle, confirm write-back during the scan
	always_comb begin
		ram_we    = (cmd.exec && is_add) || hit_match;
		ram_waddr = slot_s1;
		ram_wdata = {rec.seq, rec.stamp, rec.payload, conf_new};
		if (cmd.exec) begin
			ram_waddr = wp_q;
			ram_wdata = {next_seq_q, stamp_q, payload_q, {CONF_W{1'b0}}};
		end
	end

	assign status.issue_done = (rd_cnt_q == fill_q);
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q     <= command;
			payload_q <= payload;
			stamp_q   <= stamp_ms;
			want_q    <= confirm_sequence;
			bit_q     <= server_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			fill_q     <= '0;
			next_seq_q <= '0;
		end else if (cmd.exec) begin
			case (cmd_q)
				CMD_ADD: begin
					wp_q       <= (wp_q == LAST_SLOT) ? '0 : wp_q + AW'(1);
					fill_q     <= (fill_q == FULL) ? fill_q : fill_q + CW'(1);
					next_seq_q <= next_seq_q + SEQ_W'(1);
				end
				CMD_CLEAR: begin
					wp_q       <= '0;
					fill_q     <= '0;
					next_seq_q <= start_sequence;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= rd_slot_q;
		if (cmd.prep) begin
			rd_slot_q <= oldest_w[AW-1:0];
			rd_cnt_q  <= '0;
		end else if (cmd.scan) begin
			rd_slot_q <= (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + AW'(1);
			rd_cnt_q  <= rd_cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			matched_q <= 1'b0;
			found_q   <= 1'b0;
			pend_q    <= '0;
		end else if (valid_s1) begin
			if (hit_match) begin
				matched_q <= 1'b1;
			end
			if (!sent) begin
				pend_q <= pend_q + CW'(1);
				if (!found_q) begin
					found_q <= 1'b1;
					hit_q   <= '{seq: rec.seq, stamp: rec.stamp, payload: rec.payload,
					             conf: conf_new};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_out_q  <= (cmd_q == CMD_QUERY) && found_q;
			rec_out_q    <= ((cmd_q == CMD_QUERY) && found_q) ? hit_q : '0;
			pend_out_q   <= COUNT_W'(pend_q);
			stored_out_q <= COUNT_W'(fill_q);
		end
	end

	assign out_valid           = out_valid_q;
	assign found               = found_out_q;
	assign entry_sequence      = rec_out_q.seq;
	assign entry_stamp         = rec_out_q.stamp;
	assign entry_payload       = rec_out_q.payload;
	assign entry_confirmations = rec_out_q.conf;
	assign pending_total       = pend_out_q;
	assign stored_total        = stored_out_q;
endmodule

// ===== rtl/telemetry_ring_ack_buffer.sv =====
// Top level of the telemetry ring acknowledge buffer: APB registers plus
// controller and datapath. Depends on trab_pkg, trab_if, trab_ctrl, trab_dp.
//
// Usage:
//   req  - valid/ready request channel. Each word carries a command (add,
//          confirm, query, clear) and its operands.
//   rsp  - valid/ready response channel. Exactly one word comes back per
//          request, in order. Query answers carry the oldest record some
//          configured server has not confirmed; every answer carries the
//          pending and stored counts after the command.
//   APB  - server_mask at 0x0, start_sequence at 0x8 (paddr[3] selects).
//          Write only while no request is in flight.
// Scan: the record scan reads one record per cycle from the record RAM,
//   oldest first, over the record count after the command. A new request
//   is accepted only once the previous result has been loaded into the
//   output register.
// Reset: ring empty, sequence counter zero, both registers zero. The RAM
//   contents are not cleared; only written records are ever read.
// Stall: a response held by rsp.ready still lets the next request be
//   accepted and scanned; that result waits until the output register frees.
module telemetry_ring_ack_buffer #(
	parameter int unsigned DEPTH = trab_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	trab_req_if.sink                      req,
	trab_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [trab_pkg::APB_AW-1:0]   paddr,
	input  logic [trab_pkg::APB_DW-1:0]   pwdata,
	output logic [trab_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import trab_pkg::*;

	logic [CONF_W-1:0] server_mask_q;
	logic [SEQ_W-1:0]  start_seq_q;
	logic              reg_wr;
	logic              reg_sel;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Registers: write on the APB access phase, pready is tied high.
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[APB_AW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_mask_q <= '0;
			start_seq_q   <= '0;
		end else if (reg_wr) begin
			case (reg_sel)
				REG_SERVER_MASK:    server_mask_q <= pwdata[CONF_W-1:0];
				REG_START_SEQUENCE: start_seq_q   <= pwdata[SEQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SERVER_MASK:    prdata = APB_DW'(server_mask_q);
			REG_START_SEQUENCE: prdata = APB_DW'(start_seq_q);
			default:            prdata = '0;
		endcase
	end

	// Controller: one request at a time, accept only in idle.
	trab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: ring state, record RAM, scan and the response register.
	trab_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.command             (req.command),
		.payload             (req.payload),
		.stamp_ms            (req.stamp_ms),
		.confirm_sequence    (req.confirm_sequence),
		.server_index        (req.server_index),
		.server_mask         (server_mask_q),
		.start_sequence      (start_seq_q),
		.out_valid           (rsp.valid),
		.out_ready           (rsp.ready),
		.found               (rsp.found),
		.entry_sequence      (rsp.entry_sequence),
		.entry_stamp         (rsp.entry_stamp),
		.entry_payload       (rsp.entry_payload),
		.entry_confirmations (rsp.entry_confirmations),
		.pending_total       (rsp.pending_total),
		.stored_total        (rsp.stored_total)
	);
endmodule

// ===== rtl/trab_checker.sv =====
// Port-level checks for the telemetry ring acknowledge buffer, bound to the
// top level. Depends on trab_pkg for field widths.
module trab_checker #(
	parameter int unsigned DEPTH = trab_pkg::DEPTH_DEFAULT
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          found,
	input logic [trab_pkg::SEQ_W-1:0]     entry_sequence,
	input logic [trab_pkg::STAMP_W-1:0]   entry_stamp,
	input logic [trab_pkg::PAYLOAD_W-1:0] entry_payload,
	input logic [trab_pkg::CONF_W-1:0]    entry_confirmations,
	input logic [trab_pkg::COUNT_W-1:0]   pending_total,
	input logic [trab_pkg::COUNT_W-1:0]   stored_total
);
	import trab_pkg::*;

	localparam bit COUNTS_EXACT = (DEPTH < 128);

	// Hold a stalled response.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(found)
			&& $stable(entry_sequence) && $stable(entry_payload)
			&& $stable(pending_total) && $stable(stored_total))
		else $error("response changed while stalled");

	// Zero the record fields when nothing was found.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> entry_sequence == '0 && entry_stamp == '0
			&& entry_payload == '0 && entry_confirmations == '0)
		else $error("record fields set without a found record");

	// A found record is itself pending.
	a_found_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> pending_total != '0)
		else $error("record found with zero pending count");

	// Pending records are a subset of stored records.
	a_pend_le_stored: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && COUNTS_EXACT |-> pending_total <= stored_total)
		else $error("pending count exceeds stored count");

	// Drop ready after an accept: one request in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another was in flight");
endmodule

bind telemetry_ring_ack_buffer trab_checker #(
	.DEPTH (DEPTH)
) u_trab_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.found               (rsp.found),
	.entry_sequence      (rsp.entry_sequence),
	.entry_stamp         (rsp.entry_stamp),
	.entry_payload       (rsp.entry_payload),
	.entry_confirmations (rsp.entry_confirmations),
	.pending_total       (rsp.pending_total),
	.stored_total        (rsp.stored_total)
);
